FILE: hdl/assert_macros.svh
// assertion macros used by the checker file
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// clocked assertion, disabled while reset is asserted
`define CHK_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// implication checked in the cycle after the antecedent
`define CHK_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

FILE: hdl/ldc_pkg.sv
// package for the leader clustering block: widths, defaults, state codes
// no dependencies
package ldc_pkg;
   localparam int unsigned DefMaxClusters = 64;
   localparam int unsigned DefMaxPoints = 65536;
   localparam int unsigned CoordW = 16;
   localparam int unsigned IdxW = 6;
   localparam int unsigned MemberW = 17;
   localparam int unsigned CountW = 7;
   localparam int unsigned ThreshW = 33;
   localparam int unsigned DistW = 34;

   typedef enum logic [7:0] {
      ST_IDLE  = 8'b0000_0001,
      ST_READ  = 8'b0000_0010,
      ST_SCAN  = 8'b0000_0100,
      ST_DECIDE = 8'b0000_1000,
      ST_FETCH = 8'b0001_0000,
      ST_DIVX  = 8'b0010_0000,
      ST_DIVY  = 8'b0100_0000,
      ST_DONE  = 8'b1000_0000
   } state_type;

   typedef struct packed {
      logic start;
      logic busy;
   } div_ctl_type;
endpackage

FILE: hdl/ldc_if.sv
// valid/ready channel interfaces for request and response beats
// depends on ldc_pkg
interface ldc_req_if import ldc_pkg::*; ();
   logic valid;
   logic ready;
   logic restart;
   logic [CoordW-1:0] x_coord;
   logic [CoordW-1:0] y_coord;
   modport source (output valid, restart, x_coord, y_coord, input ready);
   modport sink (input valid, restart, x_coord, y_coord, output ready);
endinterface

interface ldc_rsp_if import ldc_pkg::*; ();
   logic valid;
   logic ready;
   logic [IdxW-1:0] cluster_index;
   logic new_cluster;
   logic table_full;
   logic [CoordW-1:0] centroid_x;
   logic [CoordW-1:0] centroid_y;
   logic [MemberW-1:0] member_count;
   logic [CountW-1:0] cluster_count;
   modport source (output valid, cluster_index, new_cluster, table_full, centroid_x,
                   centroid_y, member_count, cluster_count, input ready);
   modport sink (input valid, cluster_index, new_cluster, table_full, centroid_x,
                 centroid_y, member_count, cluster_count, output ready);
endinterface

FILE: hdl/ldc_div.sv
// restoring divider, one quotient bit per cycle, shared for both centroid axes
// depends on ldc_pkg
module ldc_div import ldc_pkg::*; #(
   parameter int unsigned NumW = 33,
   parameter int unsigned DenW = 17
) (
   input  logic clock,
   input  logic reset,
   input  logic start,
   input  logic [NumW-1:0] num,
   input  logic [DenW-1:0] den,
   output logic done,
   output logic [NumW-1:0] quot
);
   localparam int unsigned CntW = $clog2(NumW + 1);
   logic [NumW-1:0] q_ff, q_in;
   logic [DenW:0] r_ff, r_in;
   logic [DenW-1:0] d_ff, d_in;
   logic [CntW-1:0] cnt_ff, cnt_in;
   logic run_ff, run_in, done_ff, done_in;
   logic [DenW:0] trial;

   always_comb begin
      q_in = q_ff;
      r_in = r_ff;
      d_in = d_ff;
      cnt_in = cnt_ff;
      run_in = run_ff;
      done_in = 1'b0;
      trial = {r_ff[DenW-1:0], q_ff[NumW-1]};
      if (start) begin
         q_in = num;
         r_in = '0;
         d_in = den;
         cnt_in = CntW'(NumW);
         run_in = 1'b1;
      end else if (run_ff) begin
         if (trial >= {1'b0, d_ff}) begin
            r_in = trial - {1'b0, d_ff};
            q_in = {q_ff[NumW-2:0], 1'b1};
         end else begin
            r_in = trial;
            q_in = {q_ff[NumW-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CntW'(1)) begin
            run_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         run_ff <= run_in;
         done_ff <= done_in;
         cnt_ff <= cnt_in;
      end
      q_ff <= q_in;
      r_ff <= r_in;
      d_ff <= d_in;
   end

   assign done = done_ff;
   assign quot = q_ff;
endmodule

FILE: hdl/leader_clustering.sv
// leader clustering top level: sequencer, cluster memories, distance unit
// depends on ldc_pkg, ldc_if, ldc_div
//
// One request beat is one point; one response beat follows for every point.
// The block takes a point only when idle and holds req.ready low until the
// response beat has been taken. A read state comes first, then the scan gives
// one squared distance per cycle, one for each cluster in use, through one
// shared pair of 16x16 multipliers on the registered centroid read, then one
// decide state follows. A point that opens a cluster is written in decide; an
// empty table skips the scan. A point that joins a cluster adds a fetch state
// and two serial divisions, x then y, through one shared divider; a join into
// a saturated cluster skips the divisions. A response stall holds the block
// in the done state until the response beat has been taken.
// The cluster memories need no clearing: only entries of clusters in use are
// compared or fetched. threshold_sq is at csr address 0 (64-bit data lane).
module leader_clustering import ldc_pkg::*; #(
   parameter int unsigned MAX_CLUSTERS = DefMaxClusters,
   parameter int unsigned MAX_POINTS = DefMaxPoints
) (
   input  logic clock,
   input  logic reset,
   ldc_req_if.sink req,
   ldc_rsp_if.source rsp,
   input  logic csr_psel,
   input  logic csr_penable,
   input  logic csr_pwrite,
   input  logic [3:0] csr_paddr,
   input  logic [63:0] csr_pwdata,
   output logic [63:0] csr_prdata,
   output logic csr_pready
);
   localparam int unsigned CiW = $clog2(MAX_CLUSTERS);
   localparam int unsigned CuW = $clog2(MAX_CLUSTERS + 1);
   localparam int unsigned MbW = $clog2(MAX_POINTS + 1);
   localparam int unsigned SumW = MbW + CoordW;

   // cluster memories
   logic [SumW-1:0] sumx_mem [MAX_CLUSTERS];
   logic [SumW-1:0] sumy_mem [MAX_CLUSTERS];
   logic [MbW-1:0] mem_mem [MAX_CLUSTERS];
   logic [2*CoordW-1:0] cen_mem [MAX_CLUSTERS];

   state_type state_ff, state_in;
   logic [ThreshW-1:0] thr_ff, thr_in;
   logic [CuW-1:0] used_ff, used_in;
   logic [CoordW-1:0] px_ff, py_ff;
   logic [CiW-1:0] rd_addr;
   logic [CuW-1:0] scan_ff, scan_in;        // address issued to memory
   logic [CuW-1:0] cmp_ff, cmp_in;          // index of data now read out
   logic [DistW-1:0] best_ff, best_in;
   logic [CiW-1:0] sel_ff, sel_in;
   logic opened_ff, opened_in, full_ff, full_in;
   logic [2*CoordW-1:0] cen_rd;
   logic [SumW-1:0] sx_rd, sy_rd, sx_ff, sy_ff;
   logic [MbW-1:0] mb_rd, mb_ff;
   logic [CoordW-1:0] cx_ff, cx_in, cy_ff, cy_in;
   logic rsp_v_ff, rsp_v_in;
   logic wr_en;
   logic [CiW-1:0] wr_addr;
   logic [SumW-1:0] wr_sx, wr_sy;
   logic [MbW-1:0] wr_mb;
   logic [2*CoordW-1:0] wr_cen;
   logic [CoordW-1:0] dx, dy;
   logic [2*CoordW-1:0] dx_sq, dy_sq;
   logic [DistW-1:0] dsq;
   div_ctl_type div_ctl;
   logic div_done;
   logic [SumW-1:0] div_q;
   logic [SumW-1:0] div_num;
   logic div_go_ff, div_go_in;

   // csr port, 64-bit lane since threshold_sq is 33 bits
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr == 4'd0) ? 64'(thr_ff) : 64'd0;
   always_comb begin
      thr_in = thr_ff;
      if (csr_psel && csr_penable && csr_pwrite && csr_paddr == 4'd0)
         thr_in = csr_pwdata[ThreshW-1:0];
   end

   // shared distance unit on the registered centroid read
   assign dx = (px_ff >= cen_rd[2*CoordW-1:CoordW]) ? px_ff - cen_rd[2*CoordW-1:CoordW]
                                                    : cen_rd[2*CoordW-1:CoordW] - px_ff;
   assign dy = (py_ff >= cen_rd[CoordW-1:0]) ? py_ff - cen_rd[CoordW-1:0]
                                             : cen_rd[CoordW-1:0] - py_ff;
   assign dx_sq = dx * dx;
   assign dy_sq = dy * dy;
   assign dsq = DistW'(dx_sq) + DistW'(dy_sq);

   assign rd_addr = (state_ff == ST_DECIDE) ? sel_ff : scan_ff[CiW-1:0];

   always_ff @(posedge clock) begin
      cen_rd <= cen_mem[rd_addr];
      sx_rd <= sumx_mem[rd_addr];
      sy_rd <= sumy_mem[rd_addr];
      mb_rd <= mem_mem[rd_addr];
      if (wr_en) begin
         sumx_mem[wr_addr] <= wr_sx;
         sumy_mem[wr_addr] <= wr_sy;
         mem_mem[wr_addr] <= wr_mb;
         cen_mem[wr_addr] <= wr_cen;
      end
   end

   assign div_num = div_ctl.busy ? sy_ff : sx_ff;

   ldc_div #(.NumW(SumW), .DenW(MbW)) u_div (
      .clock(clock), .reset(reset), .start(div_ctl.start),
      .num(div_num), .den(mb_ff), .done(div_done), .quot(div_q)
   );

   always_comb begin
      state_in = state_ff;
      used_in = used_ff;
      scan_in = scan_ff;
      cmp_in = cmp_ff;
      best_in = best_ff;
      sel_in = sel_ff;
      opened_in = opened_ff;
      full_in = full_ff;
      cx_in = cx_ff;
      cy_in = cy_ff;
      rsp_v_in = rsp_v_ff;
      div_go_in = 1'b0;
      wr_en = 1'b0;
      wr_addr = sel_ff;
      wr_sx = sx_ff;
      wr_sy = sy_ff;
      wr_mb = mb_ff;
      wr_cen = {cx_ff, cy_ff};
      div_ctl = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req.valid) begin
               if (req.restart) used_in = '0;
               scan_in = '0;
               cmp_in = '0;
               opened_in = 1'b0;
               full_in = 1'b0;
               sel_in = '0;
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            if (used_ff == '0) begin
               opened_in = 1'b1;
               state_in = ST_DECIDE;
            end else begin
               scan_in = scan_ff + 1'b1;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            // data for cmp_ff is on cen_rd this cycle
            if (cmp_ff == '0 || dsq < best_ff) begin
               best_in = dsq;
               sel_in = cmp_ff[CiW-1:0];
            end
            if (scan_ff < used_ff) scan_in = scan_ff + 1'b1;
            cmp_in = cmp_ff + 1'b1;
            if (cmp_ff + 1'b1 == used_ff) state_in = ST_DECIDE;
         end
         ST_DECIDE: begin
            if (!opened_ff && best_ff >= DistW'(thr_ff)) begin
               if (used_ff < CuW'(MAX_CLUSTERS)) opened_in = 1'b1;
               else full_in = 1'b1;
            end
            if (opened_ff || (best_ff >= DistW'(thr_ff) && used_ff < CuW'(MAX_CLUSTERS))) begin
               sel_in = used_ff[CiW-1:0];
               used_in = used_ff + 1'b1;
               cx_in = px_ff;
               cy_in = py_ff;
               wr_en = 1'b1;
               wr_addr = used_ff[CiW-1:0];
               wr_sx = SumW'(px_ff);
               wr_sy = SumW'(py_ff);
               wr_mb = MbW'(1);
               wr_cen = {px_ff, py_ff};
               state_in = ST_DONE;
               rsp_v_in = 1'b1;
            end else begin
               state_in = ST_FETCH;   // memory now reads the selected entry
            end
         end
         ST_FETCH: begin
            // selected entry is on the read registers; sums and count land next cycle
            cx_in = cen_rd[2*CoordW-1:CoordW];
            cy_in = cen_rd[CoordW-1:0];
            if (mb_rd < MbW'(MAX_POINTS)) begin
               div_go_in = 1'b1;
               state_in = ST_DIVX;
            end else begin
               state_in = ST_DONE;
               rsp_v_in = 1'b1;
            end
         end
         ST_DIVX: begin
            if (div_go_ff) begin
               div_ctl.start = 1'b1;   // bumped sums and count now in sx_ff, mb_ff
            end else if (div_done) begin
               cx_in = div_q[CoordW-1:0];
               div_ctl.start = 1'b1;
               div_ctl.busy = 1'b1;
               state_in = ST_DIVY;
            end
         end
         ST_DIVY: begin
            if (div_done) begin
               cy_in = div_q[CoordW-1:0];
               wr_en = 1'b1;
               wr_cen = {cx_ff, div_q[CoordW-1:0]};
               state_in = ST_DONE;
               rsp_v_in = 1'b1;
            end
         end
         ST_DONE: begin
            if (rsp.ready) begin
               rsp_v_in = 1'b0;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         thr_ff <= '0;
         used_ff <= '0;
         rsp_v_ff <= 1'b0;
         div_go_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         thr_ff <= thr_in;
         used_ff <= used_in;
         rsp_v_ff <= rsp_v_in;
         div_go_ff <= div_go_in;
      end
      scan_ff <= scan_in;
      cmp_ff <= cmp_in;
      best_ff <= best_in;
      sel_ff <= sel_in;
      opened_ff <= opened_in;
      full_ff <= full_in;
      cx_ff <= cx_in;
      cy_ff <= cy_in;
      if (state_ff == ST_IDLE && req.valid) begin
         px_ff <= req.x_coord;
         py_ff <= req.y_coord;
      end
      // in fetch capture the selected entry and bump sums and count once unless saturated; decide loads the point
      if (state_ff == ST_FETCH) begin
         if (mb_rd < MbW'(MAX_POINTS)) begin
            sx_ff <= sx_rd + SumW'(px_ff);
            sy_ff <= sy_rd + SumW'(py_ff);
            mb_ff <= mb_rd + 1'b1;
         end else begin
            sx_ff <= sx_rd;
            sy_ff <= sy_rd;
            mb_ff <= mb_rd;
         end
      end else if (state_ff == ST_DECIDE) begin
         sx_ff <= SumW'(px_ff);
         sy_ff <= SumW'(py_ff);
         mb_ff <= MbW'(1);
      end
   end

   assign req.ready = (state_ff == ST_IDLE);
   assign rsp.valid = rsp_v_ff;
   assign rsp.cluster_index = IdxW'(sel_ff);
   assign rsp.new_cluster = opened_ff;
   assign rsp.table_full = full_ff;
   assign rsp.centroid_x = cx_ff;
   assign rsp.centroid_y = cy_ff;
   assign rsp.member_count = MemberW'(mb_ff);
   assign rsp.cluster_count = CountW'(used_ff);
endmodule

FILE: hdl/ldc_checker.sv
// port-level checker for leader_clustering, bound to the top level
// depends on assert_macros.svh
`include "assert_macros.svh"
module ldc_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic new_cluster,
   input logic table_full,
   input logic [16:0] member_count,
   input logic [6:0] cluster_count
);
   `CHK_ASSERT(a_no_overlap, clock, reset, !(req_ready && rsp_valid), "ready while result pending")
   `CHK_ASSERT(a_flags, clock, reset, !(rsp_valid && new_cluster && table_full), "open and full")
   `CHK_ASSERT(a_new_one, clock, reset, !(rsp_valid && new_cluster) || member_count == 17'd1,
      "new cluster count not one")
   `CHK_NEXT(a_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(cluster_count),
      "result dropped")
endmodule

bind leader_clustering ldc_checker u_ldc_checker (
   .clock(clock), .reset(reset), .req_valid(req.valid), .req_ready(req.ready),
   .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .new_cluster(rsp.new_cluster),
   .table_full(rsp.table_full), .member_count(rsp.member_count),
   .cluster_count(rsp.cluster_count)
);
